/* hw/rtl/assert_macros.svh */
// assertion macros used by the translator rtl
// include with the bare file name; clock and active-low reset are passed in
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define TLBAT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define TLBAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/tlbat_pkg.sv */
// types and constants for the tlb address translator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tlbat_pkg;

    localparam int ADDR_W = 32;
    localparam int DATA_W = 32;
    localparam int CFG_W  = 32;

    // input function codes
    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_PTE   = 2'd2,
        FUNC_RSVD  = 2'd3
    } t_func;

    // result request kinds
    typedef enum logic [2:0] {
        KIND_READ  = 3'd0,
        KIND_WRITE = 3'd1,
        KIND_FETCH = 3'd2,
        KIND_FAULT = 3'd3,
        KIND_BUSY  = 3'd4
    } t_kind;

    // configuration register indexes
    localparam logic CFG_TRANSLATE_ENABLE = 1'b0;
    localparam logic CFG_PAGE_TABLE_BASE  = 1'b1;

    // one result beat
    typedef struct packed {
        t_kind              kind;
        logic [ADDR_W-1:0]  addr;
        logic [DATA_W-1:0]  data;
        logic               hit;
    } t_result;

endpackage

`default_nettype wire

/* hw/rtl/tlbat_match.sv */
// parallel tag compare over all tlb entries, lowest matching index wins
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module tlbat_match #(
    parameter int ENTRIES   = 2,
    parameter int VPAGE_W   = 22,
    parameter int PPAGE_W   = 6
) (
    input  wire logic [ENTRIES-1:0]              i_entry_valid,
    input  wire logic [ENTRIES-1:0][VPAGE_W-1:0] i_entry_vpage,
    input  wire logic [ENTRIES-1:0][PPAGE_W-1:0] i_entry_ppage,
    input  wire logic [VPAGE_W-1:0]              i_vpage,
    output logic                                 o_hit,
    output logic [PPAGE_W-1:0]                   o_ppage
);

    logic [ENTRIES-1:0] w_match;

    // per-entry compare
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            w_match[i] = i_entry_valid[i] && (i_entry_vpage[i] == i_vpage);
        end
    end

    // priority select, walking down so the lowest index is taken last
    always_comb begin
        o_ppage = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                o_ppage = i_entry_ppage[i];
            end
        end
        o_hit = |w_match;
    end

endmodule

`default_nettype wire

/* hw/rtl/tlb_address_translator.sv */
// each result beat is registered into the output register, or into the skid behind it
// throughput: one input beat per cycle while the skid is empty; a two-deep output buffer
//   keeps input open while one result waits, all entries are tag-compared in that cycle
// a miss holds further accesses (answered busy) until the entry word beat returns
// reset (synchronous, active low) clears config, entry valid bits, victim pointer,
//   pending miss and the output buffer; no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tlb_address_translator
    import tlbat_pkg::*;
#(
    parameter int TLB_ENTRIES      = 2,
    parameter int PAGE_OFFSET_BITS = 10,
    parameter int PHYS_PAGE_BITS   = 6,
    parameter int ENTRY_BYTES      = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // configuration write port
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_index,
    input  wire logic [CFG_W-1:0]  i_cfg_wdata,
    // input channel
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [1:0]        i_func,
    input  wire logic [ADDR_W-1:0] i_virt_addr,
    input  wire logic [DATA_W-1:0] i_write_data,
    input  wire logic [DATA_W-1:0] i_pte_word,
    // output channel
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [2:0]             o_req_kind,
    output logic [ADDR_W-1:0]      o_req_addr,
    output logic [DATA_W-1:0]      o_req_data,
    output logic                   o_tlb_hit
);

    localparam int VPAGE_W = ADDR_W - PAGE_OFFSET_BITS;
    localparam int IDX_W   = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

    // configuration
    logic              r_translate_enable;
    logic [ADDR_W-1:0] r_page_table_base;

    // tlb storage
    logic [TLB_ENTRIES-1:0]                     r_entry_valid;
    logic [TLB_ENTRIES-1:0][VPAGE_W-1:0]        r_entry_vpage;
    logic [TLB_ENTRIES-1:0][PHYS_PAGE_BITS-1:0] r_entry_ppage;
    logic [IDX_W-1:0]                           r_victim;

    // pending miss
    logic              r_miss_pending;
    logic              r_pend_is_write;
    logic [ADDR_W-1:0] r_pend_vaddr;
    logic [DATA_W-1:0] r_pend_wdata;

    // output buffer
    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;

    logic                      w_in_accept;
    logic                      w_out_take;
    t_func                     w_func;
    logic                      w_is_access;
    logic [VPAGE_W-1:0]        w_vpage;
    logic                      w_hit;
    logic [PHYS_PAGE_BITS-1:0] w_hit_ppage;
    logic                      w_refill;
    logic                      w_pte_valid;
    logic                      w_miss;
    logic                      w_has_result;
    t_result                   w_res;
    logic [63:0]               w_hit_phys;
    logic [63:0]               w_fill_phys;
    logic [IDX_W-1:0]          n_victim;

    // handshake
    assign o_in_stall  = r_skid_valid;
    assign w_in_accept = i_in_valid && !r_skid_valid;
    assign w_out_take  = r_out_valid && !i_out_stall;

    assign w_func      = t_func'(i_func);
    assign w_is_access = (w_func == FUNC_READ) || (w_func == FUNC_WRITE);
    assign w_vpage     = i_virt_addr[ADDR_W-1:PAGE_OFFSET_BITS];
    assign w_pte_valid = i_pte_word[PHYS_PAGE_BITS];
    assign w_refill    = w_in_accept && (w_func == FUNC_PTE) && r_miss_pending;
    assign w_miss      = w_in_accept && w_is_access && !r_miss_pending
                         && r_translate_enable && !w_hit;

    // tag lookup
    tlbat_match #(
        .ENTRIES (TLB_ENTRIES),
        .VPAGE_W (VPAGE_W),
        .PPAGE_W (PHYS_PAGE_BITS)
    ) u_match (
        .i_entry_valid (r_entry_valid),
        .i_entry_vpage (r_entry_vpage),
        .i_entry_ppage (r_entry_ppage),
        .i_vpage       (w_vpage),
        .o_hit         (w_hit),
        .o_ppage       (w_hit_ppage)
    );

    // physical addresses, truncated to the address width
    assign w_hit_phys  = (64'(w_hit_ppage) << PAGE_OFFSET_BITS)
                         | 64'(i_virt_addr[PAGE_OFFSET_BITS-1:0]);
    assign w_fill_phys = (64'(i_pte_word[PHYS_PAGE_BITS-1:0]) << PAGE_OFFSET_BITS)
                         | 64'(r_pend_vaddr[PAGE_OFFSET_BITS-1:0]);

    // round-robin pointer advance
    assign n_victim = (r_victim == IDX_W'(TLB_ENTRIES - 1)) ? '0 : r_victim + 1'b1;

    // result for the current beat
    always_comb begin
        w_res        = '{kind: KIND_READ, addr: '0, data: '0, hit: 1'b0};
        w_has_result = 1'b0;
        priority if (w_func == FUNC_PTE) begin
            w_has_result = r_miss_pending;
            if (w_pte_valid) begin
                w_res.kind = r_pend_is_write ? KIND_WRITE : KIND_READ;
                w_res.addr = w_fill_phys[ADDR_W-1:0];
                w_res.data = r_pend_is_write ? r_pend_wdata : '0;
            end else begin
                w_res.kind = KIND_FAULT;
            end
        end else if (w_func == FUNC_RSVD) begin
            w_has_result = 1'b0;
        end else if (r_miss_pending) begin
            w_has_result = 1'b1;
            w_res.kind   = KIND_BUSY;
        end else if (!r_translate_enable) begin
            w_has_result = 1'b1;
            w_res.kind   = (w_func == FUNC_WRITE) ? KIND_WRITE : KIND_READ;
            w_res.addr   = i_virt_addr;
            w_res.data   = (w_func == FUNC_WRITE) ? i_write_data : '0;
        end else if (w_hit) begin
            w_has_result = 1'b1;
            w_res.kind   = (w_func == FUNC_WRITE) ? KIND_WRITE : KIND_READ;
            w_res.addr   = w_hit_phys[ADDR_W-1:0];
            w_res.data   = (w_func == FUNC_WRITE) ? i_write_data : '0;
            w_res.hit    = 1'b1;
        end else begin
            w_has_result = 1'b1;
            w_res.kind   = KIND_FETCH;
            w_res.addr   = r_page_table_base
                           + 32'(32'(w_vpage) * 32'(ENTRY_BYTES));
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_translate_enable <= 1'b0;
            r_page_table_base  <= '0;
            r_entry_valid      <= '0;
            r_victim           <= '0;
            r_miss_pending     <= 1'b0;
            r_out_valid        <= 1'b0;
            r_skid_valid       <= 1'b0;
        end else begin
            // config writes
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_TRANSLATE_ENABLE: r_translate_enable <= i_cfg_wdata[0];
                    CFG_PAGE_TABLE_BASE:  r_page_table_base  <= i_cfg_wdata[ADDR_W-1:0];
                    default: ;
                endcase
            end
            // miss bookkeeping and refill
            if (w_miss) begin
                r_miss_pending <= 1'b1;
            end
            if (w_refill) begin
                r_entry_valid[r_victim] <= w_pte_valid;
                r_victim                <= n_victim;
                r_miss_pending          <= 1'b0;
            end
            // output buffer occupancy
            if (w_out_take) begin
                r_skid_valid <= 1'b0;
                r_out_valid  <= r_skid_valid || (w_in_accept && w_has_result);
            end else if (w_in_accept && w_has_result) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= r_out_valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_miss) begin
            r_pend_is_write <= (w_func == FUNC_WRITE);
            r_pend_vaddr    <= i_virt_addr;
            r_pend_wdata    <= i_write_data;
        end
        if (w_refill) begin
            r_entry_vpage[r_victim] <= r_pend_vaddr[ADDR_W-1:PAGE_OFFSET_BITS];
            r_entry_ppage[r_victim] <= i_pte_word[PHYS_PAGE_BITS-1:0];
        end
        if (w_out_take) begin
            r_out <= r_skid_valid ? r_skid : w_res;
        end else if (w_in_accept && w_has_result) begin
            if (r_out_valid) begin
                r_skid <= w_res;
            end else begin
                r_out <= w_res;
            end
        end
    end

    // output beat
    assign o_out_valid = r_out_valid;
    assign o_req_kind  = r_out.kind;
    assign o_req_addr  = r_out.addr;
    assign o_req_data  = r_out.data;
    assign o_tlb_hit   = r_out.hit;

    // checks
    `TLBAT_ASSERT(a_skid_behind_out, i_clk, i_rst_n, !r_skid_valid || r_out_valid, "skid holds a beat while output register is empty")
    `TLBAT_ASSERT_NEXT(a_refill_clears_miss, i_clk, i_rst_n, i_rst_n && w_refill, !r_miss_pending, "pending miss survived its entry word")
    `TLBAT_ASSERT_NEXT(a_refill_installs, i_clk, i_rst_n, i_rst_n && w_refill && w_pte_valid, r_entry_valid[$past(r_victim)], "valid entry word not installed in victim slot")

endmodule

`default_nettype wire

/* test/tb_tlb_address_translator.sv */
`timescale 1ns / 1ps
// self-checking testbench for tlb_address_translator: directed table, then random phases
// keeps its own model of the tlb, the pending miss and the two config registers
// depends on tlbat_pkg and tlb_address_translator

module tb_tlb_address_translator;
    import tlbat_pkg::*;

    localparam int N_ENTRIES   = 2;
    localparam int PAGE_OFF    = 10;
    localparam int PPAGE_W     = 6;
    localparam int PTE_BYTES   = 4;
    localparam int TARGET_REQS = 1550;
    localparam int HOLD_CYCLES = 80;
    localparam int STALL_LIMIT = 2000;

    // one row of the directed table: a register write or an input beat
    typedef struct {
        bit              is_cfg;
        logic            cfg_idx;
        logic [CFG_W-1:0] cfg_val;
        logic [1:0]      fn;
        logic [31:0]     va;
        logic [31:0]     wd;
        logic [31:0]     pte;
        bit              typed;
        t_result         req;
    } t_row;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_cfg_we     = 1'b0;
    logic              i_cfg_index  = 1'b0;
    logic [CFG_W-1:0]  i_cfg_wdata  = '0;
    logic              i_in_valid   = 1'b0;
    logic [1:0]        i_func       = '0;
    logic [ADDR_W-1:0] i_virt_addr  = '0;
    logic [DATA_W-1:0] i_write_data = '0;
    logic [DATA_W-1:0] i_pte_word   = '0;
    logic              i_out_stall  = 1'b0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic [2:0]        o_req_kind;
    logic [ADDR_W-1:0] o_req_addr;
    logic [DATA_W-1:0] o_req_data;
    logic              o_tlb_hit;

    // translation model state
    logic              xlate_on = 1'b0;
    logic [31:0]       pt_base  = '0;
    logic              tlb_valid [N_ENTRIES] = '{default: 1'b0};
    logic [21:0]       tlb_vpage [N_ENTRIES] = '{default: '0};
    logic [PPAGE_W-1:0] tlb_ppage [N_ENTRIES] = '{default: '0};
    logic [0:0]        refill_slot   = '0;
    logic              refill_wait   = 1'b0;
    logic              wait_is_write = 1'b0;
    logic [31:0]       wait_vaddr    = '0;
    logic [31:0]       wait_wdata    = '0;

    t_result           predicted_reqs [$];
    t_row              dir_rows [$];
    logic [21:0]       page_pool [4] = '{default: '0};
    int                answered_beats = 0;
    int                mismatches     = 0;
    int                idle_pct       = 13;
    bit                hold_req       = 1'b0;
    bit                hold_done      = 1'b0;
    int                hold_left      = 0;
    int                idle_cycles    = 0;

    tlb_address_translator dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_virt_addr  (i_virt_addr),
        .i_write_data (i_write_data),
        .i_pte_word   (i_pte_word),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_req_kind   (o_req_kind),
        .o_req_addr   (o_req_addr),
        .o_req_data   (o_req_data),
        .o_tlb_hit    (o_tlb_hit)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [31:0] phys_addr(logic [PPAGE_W-1:0] pp, logic [31:0] va);
        return 32'({pp, va[PAGE_OFF-1:0]});
    endfunction

    function automatic t_result access_req(bit is_wr, logic [31:0] addr, logic [31:0] wd,
                                           logic hit);
        t_result r;
        if (is_wr) begin
            r = '{kind: KIND_WRITE, addr: addr, data: wd, hit: hit};
        end else begin
            r = '{kind: KIND_READ, addr: addr, data: '0, hit: hit};
        end
        return r;
    endfunction

    // model of one accepted input beat; updates the tlb and pending miss state
    task automatic translate_beat(input logic [1:0] fn, input logic [31:0] va,
                                  input logic [31:0] wd, input logic [31:0] pte,
                                  output bit produced, output t_result req);
        logic [21:0] vpage;
        bit          found;
        int          hit_idx;
        produced = 1'b1;
        req      = '{kind: KIND_BUSY, addr: '0, data: '0, hit: 1'b0};
        vpage    = va[31:PAGE_OFF];
        found    = 1'b0;
        hit_idx  = 0;
        if (fn == FUNC_PTE) begin
            if (!refill_wait) begin
                produced = 1'b0;
            end else begin
                // install round robin, even when the entry word is invalid
                tlb_valid[refill_slot] = pte[PPAGE_W];
                tlb_vpage[refill_slot] = wait_vaddr[31:PAGE_OFF];
                tlb_ppage[refill_slot] = pte[PPAGE_W-1:0];
                refill_slot = refill_slot + 1'b1;
                refill_wait = 1'b0;
                if (pte[PPAGE_W]) begin
                    req = access_req(wait_is_write, phys_addr(pte[PPAGE_W-1:0], wait_vaddr),
                                     wait_wdata, 1'b0);
                end else begin
                    req.kind = KIND_FAULT;
                end
            end
        end else if (fn == FUNC_RSVD) begin
            produced = 1'b0;
        end else if (refill_wait) begin
            req.kind = KIND_BUSY;
        end else if (!xlate_on) begin
            req = access_req(fn == FUNC_WRITE, va, wd, 1'b0);
        end else begin
            // lowest matching index wins
            for (int i = N_ENTRIES - 1; i >= 0; i--) begin
                if (tlb_valid[i] && tlb_vpage[i] == vpage) begin
                    found   = 1'b1;
                    hit_idx = i;
                end
            end
            if (found) begin
                req = access_req(fn == FUNC_WRITE, phys_addr(tlb_ppage[hit_idx], va), wd, 1'b1);
            end else begin
                refill_wait   = 1'b1;
                wait_is_write = (fn == FUNC_WRITE);
                wait_vaddr    = va;
                wait_wdata    = wd;
                req = '{kind: KIND_FETCH, addr: pt_base + 32'(vpage) * 32'(PTE_BYTES),
                        data: '0, hit: 1'b0};
            end
        end
    endtask

    // offer one beat, with random gaps, and predict it once accepted
    task automatic send_beat(input logic [1:0] fn, input logic [31:0] va,
                             input logic [31:0] wd, input logic [31:0] pte,
                             input bit typed, input t_result typed_req);
        bit      produced;
        t_result req;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_func       <= fn;
        i_virt_addr  <= va;
        i_write_data <= wd;
        i_pte_word   <= pte;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        translate_beat(fn, va, wd, pte, produced, req);
        if (typed) predicted_reqs.push_back(typed_req);
        else if (produced) predicted_reqs.push_back(req);
        if (produced) answered_beats++;
    endtask

    // stop offering and let every predicted request drain
    task automatic settle();
        i_in_valid <= 1'b0;
        while (predicted_reqs.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_TRANSLATE_ENABLE) xlate_on = val[0];
        else pt_base = val;
        @(posedge i_clk);
    endtask

    // random beat, mostly well-formed: a refill answers a pending miss
    task automatic rand_beat();
        int          pick;
        logic [1:0]  fn;
        logic [31:0] va;
        logic [31:0] wd;
        logic [31:0] pte;
        pick = $urandom_range(99);
        wd   = $urandom;
        pte  = $urandom;
        va   = {page_pool[$urandom_range(3)], 10'($urandom)};
        if (pick < 8) va = $urandom;
        fn = $urandom_range(1) ? FUNC_WRITE : FUNC_READ;
        if (refill_wait) begin
            if (pick < 78) begin
                fn = FUNC_PTE;
                pte[PPAGE_W] = ($urandom_range(99) < 85);
            end else if (pick < 84) begin
                fn = FUNC_RSVD;
            end
        end else if (pick >= 96) begin
            fn = FUNC_RSVD;
        end else if (pick >= 92) begin
            fn = FUNC_PTE;
        end
        send_beat(fn, va, wd, pte, 1'b0, '0);
    endtask

    function automatic t_row beat_row(logic [1:0] fn, logic [31:0] va, logic [31:0] wd,
                                      logic [31:0] pte);
        t_row r;
        r = '{is_cfg: 1'b0, cfg_idx: 1'b0, cfg_val: '0, fn: fn, va: va, wd: wd, pte: pte,
              typed: 1'b0, req: '0};
        return r;
    endfunction

    function automatic t_row typed_row(logic [1:0] fn, logic [31:0] va, logic [31:0] wd,
                                       logic [31:0] pte, t_kind k, logic [31:0] a,
                                       logic [31:0] d, logic h);
        t_row r;
        r       = beat_row(fn, va, wd, pte);
        r.typed = 1'b1;
        r.req   = '{kind: k, addr: a, data: d, hit: h};
        return r;
    endfunction

    function automatic t_row cfg_row(logic idx, logic [CFG_W-1:0] val);
        t_row r;
        r         = beat_row(FUNC_READ, '0, '0, '0);
        r.is_cfg  = 1'b1;
        r.cfg_idx = idx;
        r.cfg_val = val;
        return r;
    endfunction

    // stimulus: reset, directed table, random phases
    initial begin
        int       phase;
        int       n_beats;
        logic [31:0] base;
        t_row     row;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // passthrough after reset, ignored codes
        dir_rows.push_back(typed_row(FUNC_READ, 32'h0, 32'h0, 32'h0,
                                     KIND_READ, 32'h0, 32'h0, 1'b0));
        dir_rows.push_back(typed_row(FUNC_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                     KIND_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
        dir_rows.push_back(beat_row(FUNC_PTE, 32'h0, 32'h0, 32'h0000_007F));
        dir_rows.push_back(beat_row(FUNC_RSVD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        // top page table base: fetch address wraps
        dir_rows.push_back(cfg_row(CFG_PAGE_TABLE_BASE, 32'hFFFF_FFFC));
        dir_rows.push_back(cfg_row(CFG_TRANSLATE_ENABLE, 32'h1));
        dir_rows.push_back(typed_row(FUNC_READ, 32'hFFFF_FFFF, 32'h0, 32'h0,
                                     KIND_FETCH, 32'h00FF_FFF8, 32'h0, 1'b0));
        // access while waiting is rejected, reserved code ignored
        dir_rows.push_back(typed_row(FUNC_WRITE, 32'h0000_1234, 32'h0000_ABCD, 32'h0,
                                     KIND_BUSY, 32'h0, 32'h0, 1'b0));
        dir_rows.push_back(beat_row(FUNC_RSVD, 32'h0, 32'h0, 32'h0));
        dir_rows.push_back(typed_row(FUNC_PTE, 32'h0, 32'h0, 32'h0000_007F,
                                     KIND_READ, 32'h0000_FFFF, 32'h0, 1'b0));
        dir_rows.push_back(typed_row(FUNC_READ, 32'hFFFF_FC00, 32'h0, 32'h0,
                                     KIND_READ, 32'h0000_FC00, 32'h0, 1'b1));
        // invalid entry word gives a fault, entry still installed
        dir_rows.push_back(typed_row(FUNC_WRITE, 32'h0, 32'h1234_5678, 32'h0,
                                     KIND_FETCH, 32'hFFFF_FFFC, 32'h0, 1'b0));
        dir_rows.push_back(typed_row(FUNC_PTE, 32'h0, 32'h0, 32'hFFFF_FFBF,
                                     KIND_FAULT, 32'h0, 32'h0, 1'b0));
        dir_rows.push_back(beat_row(FUNC_READ, 32'h0000_03FF, 32'h0, 32'h0));
        // disable while a refill is pending
        dir_rows.push_back(cfg_row(CFG_TRANSLATE_ENABLE, 32'h0));
        dir_rows.push_back(beat_row(FUNC_PTE, 32'h0, 32'h0, 32'h0000_0041));
        dir_rows.push_back(typed_row(FUNC_WRITE, 32'h0000_ABCD, 32'h5A5A_5A5A, 32'h0,
                                     KIND_WRITE, 32'h0000_ABCD, 32'h5A5A_5A5A, 1'b0));
        dir_rows.push_back(cfg_row(CFG_PAGE_TABLE_BASE, 32'h0));
        dir_rows.push_back(cfg_row(CFG_TRANSLATE_ENABLE, 32'h1));
        dir_rows.push_back(beat_row(FUNC_WRITE, 32'h0000_0155, 32'hFFFF_FFFF, 32'h0));
        dir_rows.push_back(beat_row(FUNC_READ, 32'hFFFF_FFFF, 32'h0, 32'h0));
        dir_rows.push_back(beat_row(FUNC_PTE, 32'h0, 32'h0, 32'hFFFF_FFFF));
        dir_rows.push_back(beat_row(FUNC_READ, 32'h8000_0000, 32'h0, 32'h0));
        dir_rows.push_back(typed_row(FUNC_PTE, 32'h0, 32'h0, 32'h0,
                                     KIND_FAULT, 32'h0, 32'h0, 1'b0));

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.is_cfg) begin
                settle();
                write_reg(row.cfg_idx, row.cfg_val);
            end else begin
                send_beat(row.fn, row.va, row.wd, row.pte, row.typed, row.req);
            end
        end

        // random phases, each with its own register setting and page pool
        phase = 0;
        while (answered_beats < TARGET_REQS) begin
            settle();
            write_reg(CFG_TRANSLATE_ENABLE, 32'($urandom_range(9) < 8));
            case ($urandom_range(3))
                0:       base = 32'h0;
                1:       base = 32'hFFFF_FFFF;
                2:       base = 32'hFFFF_F000;
                default: base = $urandom;
            endcase
            write_reg(CFG_PAGE_TABLE_BASE, base);
            page_pool[0] = 22'h0;
            page_pool[1] = 22'h3F_FFFF;
            page_pool[2] = 22'($urandom);
            page_pool[3] = page_pool[2] + 22'h1;
            idle_pct = (phase == 2) ? 0 : 13;
            if (phase == 4) hold_req = 1'b1;
            n_beats = $urandom_range(140, 60);
            repeat (n_beats) rand_beat();
            phase++;
        end

        settle();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tlb_address_translator verification clean");
        end else begin
            $display("tlb_address_translator verification failed");
        end
        $finish;
    end

    task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
        if (mismatches < 40)
            $display("%0t ns: %s mismatch, expected %h got %h", $time, field, want, got);
        mismatches++;
    endtask

    // result side: check each accepted beat, drive random stall and one long hold-off
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (predicted_reqs.size() == 0) begin
                if (mismatches < 40)
                    $display("%0t ns: request beat with none predicted, kind %0d addr %h",
                             $time, o_req_kind, o_req_addr);
                mismatches++;
            end else begin
                want = predicted_reqs.pop_front();
                if (o_req_kind !== want.kind) report_field("req_kind", 32'(want.kind),
                                                           32'(o_req_kind));
                if (o_req_addr !== want.addr) report_field("req_addr", want.addr, o_req_addr);
                if (o_req_data !== want.data) report_field("req_data", want.data, o_req_data);
                if (o_tlb_hit !== want.hit) report_field("tlb_hit", 32'(want.hit),
                                                         32'(o_tlb_hit));
            end
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else if (hold_req && !hold_done) begin
            hold_done   = 1'b1;
            hold_left   = HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tlb_address_translator verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
